@@ rtl/core/gbs_pkg.sv @@
// ----------------------------------------------------------------------------
// gbs_pkg: shared types and constants for the box suppression unit
// Box record, queued command, result beat and engine state encoding.
// ----------------------------------------------------------------------------
package gbs_pkg;

   localparam int RESULT_LIMIT      = 64;
   localparam int SURV_AW           = 6;
   localparam int CAP_W             = 7;
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_AW          = 2;
   localparam int QUEUE_CW          = 3;
   localparam int CSR_IDX_W         = 8;
   localparam int CSR_DATA_W        = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_IOU_THRESHOLD = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RESULTS   = 8'd1;

   localparam logic [15:0]      IOU_RESET         = 16'd29491;
   localparam logic [CAP_W-1:0] MAX_RESULTS_RESET = 7'd64;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [14:0] w;
      logic [14:0] h;
      logic [15:0] conf;
      logic [7:0]  cls;
   } box_type;

   typedef struct packed {
      logic    has_det;
      logic    frame_end;
      box_type box;
   } cmd_type;

   typedef struct packed {
      logic    result_valid;
      box_type box;
      logic    overflowed;
      logic    last;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_SCAN_RD,
      ST_SCAN_LD,
      ST_CHK,
      ST_CHK_GO,
      ST_OVL_WAIT,
      ST_EMIT,
      ST_END
   } state_type;

endpackage

@@ rtl/core/gbs_front.sv @@
// ----------------------------------------------------------------------------
// gbs_front: request intake and command queue
// Accepts request beats, drops items with no box and no frame end, and
// queues the rest for the engine.
// ----------------------------------------------------------------------------
module gbs_front
   import gbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  cmd_type req_cmd,
   output logic    q_valid,
   output cmd_type q_head,
   input  logic    q_pop
);

   cmd_type               q_mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   cnt_ff, cnt_in;
   logic                  push;
   logic                  pop;

   assign req_ready = (cnt_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready && (req_cmd.has_det || req_cmd.frame_end);
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_head    = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QUEUE_CW'(push) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= req_cmd;
      end
   end

endmodule

@@ rtl/core/gbs_overlap.sv @@
// ----------------------------------------------------------------------------
// gbs_overlap: pipelined IoU threshold test
// Five-stage test of inter * 65536 > threshold * union for two boxes.
// ----------------------------------------------------------------------------
module gbs_overlap
   import gbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  box_type     box_a,
   input  box_type     box_b,
   input  logic [15:0] threshold,
   output logic        done,
   output logic        hit
);

   logic [4:0]         v_ff;
   logic [14:0]        iw_ff, ih_ff, aw_ff, ah_ff, bw_ff, bh_ff;
   logic [29:0]        inter_ff, area_a_ff, area_b_ff, inter2_ff, inter3_ff;
   logic [30:0]        uni_ff;
   logic [46:0]        prod_ff;
   logic               hit_ff;

   logic signed [17:0] ax1, ay1, bx1, by1, ax2, ay2, bx2, by2;
   logic signed [17:0] ix1, iy1, ix2, iy2, dx, dy;
   logic [14:0]        iw_in, ih_in;

   // corners widened so right and bottom edges cannot wrap
   always_comb begin
      ax1 = {{2{box_a.x[15]}}, box_a.x};
      ay1 = {{2{box_a.y[15]}}, box_a.y};
      bx1 = {{2{box_b.x[15]}}, box_b.x};
      by1 = {{2{box_b.y[15]}}, box_b.y};
      ax2 = ax1 + signed'({3'b000, box_a.w});
      ay2 = ay1 + signed'({3'b000, box_a.h});
      bx2 = bx1 + signed'({3'b000, box_b.w});
      by2 = by1 + signed'({3'b000, box_b.h});
      ix1 = (ax1 > bx1) ? ax1 : bx1;
      iy1 = (ay1 > by1) ? ay1 : by1;
      ix2 = (ax2 < bx2) ? ax2 : bx2;
      iy2 = (ay2 < by2) ? ay2 : by2;
      dx  = ix2 - ix1;
      dy  = iy2 - iy1;
      iw_in = (ix2 > ix1) ? dx[14:0] : '0;
      ih_in = (iy2 > iy1) ? dy[14:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[3:0], start};
      end
   end

   always_ff @(posedge clock) begin
      iw_ff     <= iw_in;
      ih_ff     <= ih_in;
      aw_ff     <= box_a.w;
      ah_ff     <= box_a.h;
      bw_ff     <= box_b.w;
      bh_ff     <= box_b.h;
      inter_ff  <= iw_ff * ih_ff;
      area_a_ff <= aw_ff * ah_ff;
      area_b_ff <= bw_ff * bh_ff;
      uni_ff    <= {1'b0, area_a_ff} + {1'b0, area_b_ff} - {1'b0, inter_ff};
      inter2_ff <= inter_ff;
      prod_ff   <= threshold * uni_ff;
      inter3_ff <= inter2_ff;
      hit_ff    <= ({1'b0, inter3_ff, 16'h0000} > prod_ff);
   end

   assign done = v_ff[4];
   assign hit  = hit_ff;

endmodule

@@ rtl/core/gbs_back.sv @@
// ----------------------------------------------------------------------------
// gbs_back: sorted store and suppression engine
// Inserts boxes in rank order, then scans them against the survivor list
// and drives the response register.
// ----------------------------------------------------------------------------
module gbs_back
   import gbs_pkg::*;
#(
   parameter int MAX_DETS = 256
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  cmd_type          q_head,
   output logic             q_pop,
   input  logic [15:0]      threshold,
   input  logic [CAP_W-1:0] cap,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output result_type       rsp_data
);

   localparam int AW = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
   localparam int CW = $clog2(MAX_DETS + 1);

   state_type          state_ff, state_in;
   cmd_type            cur_ff, cur_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic               ovf_ff, ovf_in;
   logic [CAP_W-1:0]   n_ff, n_in;
   logic [CAP_W-1:0]   k_ff, k_in;
   box_type            cand_ff, cand_in;
   box_type            pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   box_type            box_mem_ff [MAX_DETS];
   box_type            box_rd_ff;
   box_type            surv_mem_ff [RESULT_LIMIT];
   box_type            surv_rd_ff;

   logic               box_we;
   logic [AW-1:0]      box_wa;
   box_type            box_wd;
   logic [AW-1:0]      box_ra;
   logic               surv_we;
   logic               ovl_start;
   logic               ovl_done;
   logic               ovl_hit;
   logic               rsp_free;
   logic [CW-1:0]      pos_dec;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign pos_dec  = pos_ff - 1'b1;

   gbs_overlap u_ovl (
      .clock     (clock),
      .reset     (reset),
      .start     (ovl_start),
      .box_a     (surv_rd_ff),
      .box_b     (cand_ff),
      .threshold (threshold),
      .done      (ovl_done),
      .hit       (ovl_hit)
   );

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      cand_in      = cand_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cur_in = q_head;
               pos_in = '0;
               n_in   = '0;
               if (q_head.has_det && (cnt_ff != CW'(MAX_DETS))) begin
                  pos_in   = cnt_ff;
                  state_in = ST_INS_RD;
               end else begin
                  if (q_head.has_det) begin
                     ovf_in = 1'b1;
                  end
                  state_in = q_head.frame_end ? ST_SCAN_RD : ST_IDLE;
               end
            end
         end
         ST_INS_RD: begin
            if (pos_ff == '0) begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = cur_ff.frame_end ? ST_SCAN_RD : ST_IDLE;
            end else begin
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (box_rd_ff.conf >= cur_ff.box.conf) begin
               cnt_in   = cnt_ff + 1'b1;
               pos_in   = '0;
               state_in = cur_ff.frame_end ? ST_SCAN_RD : ST_IDLE;
            end else begin
               pos_in   = pos_dec;
               state_in = ST_INS_RD;
            end
         end
         ST_SCAN_RD: begin
            if ((pos_ff == cnt_ff) || (n_ff == cap)) begin
               state_in = ST_END;
            end else begin
               state_in = ST_SCAN_LD;
            end
         end
         ST_SCAN_LD: begin
            cand_in  = box_rd_ff;
            k_in     = '0;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            state_in = (k_ff == n_ff) ? ST_EMIT : ST_CHK_GO;
         end
         ST_CHK_GO: begin
            state_in = ST_OVL_WAIT;
         end
         ST_OVL_WAIT: begin
            if (ovl_done) begin
               if (ovl_hit) begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = ST_SCAN_RD;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_CHK;
               end
            end
         end
         ST_EMIT: begin
            // previous survivor goes out only once a later one is known
            if ((n_ff == '0) || rsp_free) begin
               if (n_ff != '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{result_valid: 1'b1, box: pend_ff,
                                   overflowed: ovf_ff, last: 1'b0};
               end
               pend_in  = cand_ff;
               n_in     = n_ff + 1'b1;
               pos_in   = pos_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_END: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (n_ff == '0) begin
                  rsp_in = '{result_valid: 1'b0, box: '0,
                             overflowed: ovf_ff, last: 1'b1};
               end else begin
                  rsp_in = '{result_valid: 1'b1, box: pend_ff,
                             overflowed: ovf_ff, last: 1'b1};
               end
               cnt_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memory ports, queue pop, overlap launch
   always_comb begin
      q_pop     = 1'b0;
      box_we    = 1'b0;
      box_wa    = pos_ff[AW-1:0];
      box_wd    = cur_ff.box;
      box_ra    = pos_ff[AW-1:0];
      surv_we   = 1'b0;
      ovl_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            q_pop = q_valid;
         end
         ST_INS_RD: begin
            box_we = (pos_ff == '0);
            box_ra = pos_dec[AW-1:0];
         end
         ST_INS_CMP: begin
            box_we = 1'b1;
            if (box_rd_ff.conf < cur_ff.box.conf) begin
               box_wd = box_rd_ff;
            end
         end
         ST_CHK_GO: begin
            ovl_start = 1'b1;
         end
         ST_EMIT: begin
            surv_we = 1'b1;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         n_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      cand_ff <= cand_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (box_we) begin
         box_mem_ff[box_wa] <= box_wd;
      end
      box_rd_ff <= box_mem_ff[box_ra];
   end

   always_ff @(posedge clock) begin
      if (surv_we) begin
         surv_mem_ff[n_ff[SURV_AW-1:0]] <= cand_ff;
      end
      surv_rd_ff <= surv_mem_ff[k_ff[SURV_AW-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_DETS))
      else $error("entry count past store depth");

   a_emit_checked: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> (k_ff == n_ff && n_ff < cap))
      else $error("survivor emitted before full check or past cap");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_END && rsp_free) |=>
         (state_ff == ST_IDLE && cnt_ff == '0 && rsp_valid_ff && rsp_ff.last))
      else $error("frame close did not clear state or flag last beat");

   a_last_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff && rsp_in.last) |-> state_ff == ST_END)
      else $error("last beat raised outside frame close");

endmodule

@@ rtl/core/greedy_box_suppression_unit.sv @@
// ----------------------------------------------------------------------------
// greedy_box_suppression_unit: class-agnostic greedy IoU suppression
// Loads a frame of boxes in rank order and emits the survivors.
// ----------------------------------------------------------------------------
// A frame is a run of request beats closed by one with frame_end set. Each box
// is inserted into a store kept in descending confidence order (equal scores
// stay in arrival order); insertion walks the store from its tail, moving
// each entry ranked below the new box down one place before writing it.
// Past MAX_DETS entries boxes are dropped and input_overflowed is set on
// every result of that frame. At frame end, each box in rank order is
// tested against the survivors kept so far through a five-stage IoU unit;
// a box overlapping none survives. Survivors go out in rank order, at most
// max_results_out (0 acts as 1, above 64 as 64), the final beat flagged
// last_of_frame; an empty frame yields one beat with result_valid low. A
// four-deep command queue lets requests keep flowing while the engine
// works, until it fills. Configuration writes are taken at once and must
// only be issued while the unit is idle. No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
module greedy_box_suppression_unit
   import gbs_pkg::*;
#(
   parameter int MAX_DETS = 256
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_has_detection,
   input  logic signed [15:0]    req_x_left,
   input  logic signed [15:0]    req_y_top,
   input  logic [14:0]           req_box_width,
   input  logic [14:0]           req_box_height,
   input  logic [15:0]           req_confidence_q16,
   input  logic [7:0]            req_class_index,
   input  logic                  req_frame_end,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_result_valid,
   output logic signed [15:0]    rsp_out_x_left,
   output logic signed [15:0]    rsp_out_y_top,
   output logic [14:0]           rsp_out_width,
   output logic [14:0]           rsp_out_height,
   output logic [15:0]           rsp_out_confidence,
   output logic [7:0]            rsp_out_class,
   output logic                  rsp_input_overflowed,
   output logic                  rsp_last_of_frame,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [15:0]      iou_thr_ff;
   logic [CAP_W-1:0] max_out_ff;
   logic [CAP_W-1:0] cap;
   cmd_type          req_cmd;
   logic             q_valid;
   cmd_type          q_head;
   logic             q_pop;
   result_type       rsp_data;

   // registers always take a write beat
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         iou_thr_ff <= IOU_RESET;
         max_out_ff <= MAX_RESULTS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IOU_THRESHOLD: iou_thr_ff <= csr_data;
            CSR_MAX_RESULTS:   max_out_ff <= csr_data[CAP_W-1:0];
            default:           iou_thr_ff <= iou_thr_ff;
         endcase
      end
   end

   // clamp the cap into 1..RESULT_LIMIT
   always_comb begin
      if (max_out_ff == '0) begin
         cap = CAP_W'(1);
      end else if (max_out_ff > CAP_W'(RESULT_LIMIT)) begin
         cap = CAP_W'(RESULT_LIMIT);
      end else begin
         cap = max_out_ff;
      end
   end

   assign req_cmd = '{has_det:   req_has_detection,
                      frame_end: req_frame_end,
                      box: '{x: req_x_left, y: req_y_top, w: req_box_width,
                             h: req_box_height, conf: req_confidence_q16,
                             cls: req_class_index}};

   gbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   gbs_back #(
      .MAX_DETS (MAX_DETS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .threshold (iou_thr_ff),
      .cap       (cap),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_result_valid     = rsp_data.result_valid;
   assign rsp_out_x_left       = rsp_data.box.x;
   assign rsp_out_y_top        = rsp_data.box.y;
   assign rsp_out_width        = rsp_data.box.w;
   assign rsp_out_height       = rsp_data.box.h;
   assign rsp_out_confidence   = rsp_data.box.conf;
   assign rsp_out_class        = rsp_data.box.cls;
   assign rsp_input_overflowed = rsp_data.overflowed;
   assign rsp_last_of_frame    = rsp_data.last;

endmodule

@@ dv/gbs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_checker: prediction and result checking for the box suppression unit
// Watches the request, result and register channels, keeps its own ranked
// box list per frame and compares every result beat with the oldest one due.
// ----------------------------------------------------------------------------
module gbs_checker
   import gbs_pkg::*;
#(
   parameter int MAX_DETS = 256
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_has_detection,
   input  logic signed [15:0]    req_x_left,
   input  logic signed [15:0]    req_y_top,
   input  logic [14:0]           req_box_width,
   input  logic [14:0]           req_box_height,
   input  logic [15:0]           req_confidence_q16,
   input  logic [7:0]            req_class_index,
   input  logic                  req_frame_end,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_result_valid,
   input  logic signed [15:0]    rsp_out_x_left,
   input  logic signed [15:0]    rsp_out_y_top,
   input  logic [14:0]           rsp_out_width,
   input  logic [14:0]           rsp_out_height,
   input  logic [15:0]           rsp_out_confidence,
   input  logic [7:0]            rsp_out_class,
   input  logic                  rsp_input_overflowed,
   input  logic                  rsp_last_of_frame,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    pending_beats,
   output int                    error_count
);

   logic [15:0]      iou_thr;
   logic [CAP_W-1:0] result_cap;
   box_type          ranked_boxes[$];
   logic             dropped_box;
   result_type       due_results[$];

   assign pending_beats = due_results.size();

   // exact IoU test without division
   function automatic bit overlap_exceeds(box_type a, box_type b, logic [15:0] thr);
      longint ax1, ay1, bx1, by1, ax2, ay2, bx2, by2, ix1, iy1, ix2, iy2;
      longint iw, ih, inter, uni;
      ax1 = longint'($signed(a.x));
      ay1 = longint'($signed(a.y));
      bx1 = longint'($signed(b.x));
      by1 = longint'($signed(b.y));
      ax2 = ax1 + longint'(a.w);
      ay2 = ay1 + longint'(a.h);
      bx2 = bx1 + longint'(b.w);
      by2 = by1 + longint'(b.h);
      ix1 = (ax1 > bx1) ? ax1 : bx1;
      iy1 = (ay1 > by1) ? ay1 : by1;
      ix2 = (ax2 < bx2) ? ax2 : bx2;
      iy2 = (ay2 < by2) ? ay2 : by2;
      iw = (ix2 > ix1) ? ix2 - ix1 : 0;
      ih = (iy2 > iy1) ? iy2 - iy1 : 0;
      inter = iw * ih;
      uni = longint'(a.w) * longint'(a.h) + longint'(b.w) * longint'(b.h) - inter;
      return inter * 65536 > longint'(thr) * uni;
   endfunction

   task automatic rank_box(box_type b);
      int pos;
      pos = 0;
      if (ranked_boxes.size() >= MAX_DETS) begin
         dropped_box = 1'b1;
         return;
      end
      while (pos < ranked_boxes.size() && ranked_boxes[pos].conf >= b.conf)
         pos++;
      ranked_boxes.insert(pos, b);
   endtask

   task automatic suppress_frame();
      int         cap, kept;
      bit         gone[MAX_DETS];
      result_type r;
      cap = (result_cap == 0) ? 1 : ((result_cap > RESULT_LIMIT) ? RESULT_LIMIT : result_cap);
      kept = 0;
      for (int i = 0; i < MAX_DETS; i++) gone[i] = 1'b0;
      for (int i = 0; i < ranked_boxes.size() && kept < cap; i++) begin
         if (gone[i]) continue;
         r.result_valid = 1'b1;
         r.box = ranked_boxes[i];
         r.overflowed = dropped_box;
         r.last = 1'b0;
         due_results.insert(due_results.size(), r);
         kept++;
         for (int j = i + 1; j < ranked_boxes.size(); j++)
            if (!gone[j] && overlap_exceeds(ranked_boxes[i], ranked_boxes[j], iou_thr))
               gone[j] = 1'b1;
      end
      if (kept == 0) begin
         r = '0;
         r.overflowed = dropped_box;
         due_results.insert(due_results.size(), r);
      end
      due_results[due_results.size() - 1].last = 1'b1;
      ranked_boxes.delete();
      dropped_box = 1'b0;
   endtask

   task automatic check_beat();
      result_type e;
      if (due_results.size() == 0) begin
         $error("result beat with nothing expected");
         error_count++;
         return;
      end
      e = due_results.pop_front();
      if (rsp_result_valid !== e.result_valid) begin
         $error("result_valid exp %0d got %0d", e.result_valid, rsp_result_valid);
         error_count++;
      end
      if (rsp_out_x_left !== e.box.x) begin
         $error("out_x_left exp %0d got %0d", $signed(e.box.x), rsp_out_x_left);
         error_count++;
      end
      if (rsp_out_y_top !== e.box.y) begin
         $error("out_y_top exp %0d got %0d", $signed(e.box.y), rsp_out_y_top);
         error_count++;
      end
      if (rsp_out_width !== e.box.w) begin
         $error("out_width exp %0d got %0d", e.box.w, rsp_out_width);
         error_count++;
      end
      if (rsp_out_height !== e.box.h) begin
         $error("out_height exp %0d got %0d", e.box.h, rsp_out_height);
         error_count++;
      end
      if (rsp_out_confidence !== e.box.conf) begin
         $error("out_confidence exp %0d got %0d", e.box.conf, rsp_out_confidence);
         error_count++;
      end
      if (rsp_out_class !== e.box.cls) begin
         $error("out_class exp %0d got %0d", e.box.cls, rsp_out_class);
         error_count++;
      end
      if (rsp_input_overflowed !== e.overflowed) begin
         $error("input_overflowed exp %0d got %0d", e.overflowed, rsp_input_overflowed);
         error_count++;
      end
      if (rsp_last_of_frame !== e.last) begin
         $error("last_of_frame exp %0d got %0d", e.last, rsp_last_of_frame);
         error_count++;
      end
   endtask

   initial error_count = 0;

   always @(posedge clock) begin
      box_type b;
      if (reset) begin
         iou_thr <= IOU_RESET;
         result_cap <= MAX_RESULTS_RESET;
         ranked_boxes.delete();
         dropped_box = 1'b0;
         due_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IOU_THRESHOLD)
               iou_thr <= csr_data;
            else if (csr_index == CSR_MAX_RESULTS)
               result_cap <= csr_data[CAP_W-1:0];
         end
         if (req_valid && req_ready) begin
            b.x = req_x_left;
            b.y = req_y_top;
            b.w = req_box_width;
            b.h = req_box_height;
            b.conf = req_confidence_q16;
            b.cls = req_class_index;
            if (req_has_detection) rank_box(b);
            if (req_frame_end) suppress_frame();
         end
         if (rsp_valid && rsp_ready) check_beat();
      end
   end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the greedy box suppression unit
// Directed frames for edges and ties, then random frames under several
// thresholds and caps, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
   import gbs_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int SETTLE_CYCLES  = 800;   // allows for the insertion walk over the stored entries
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 8'd9;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_has_detection;
   logic signed [15:0]    req_x_left;
   logic signed [15:0]    req_y_top;
   logic [14:0]           req_box_width;
   logic [14:0]           req_box_height;
   logic [15:0]           req_confidence_q16;
   logic [7:0]            req_class_index;
   logic                  req_frame_end;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_result_valid;
   logic signed [15:0]    rsp_out_x_left;
   logic signed [15:0]    rsp_out_y_top;
   logic [14:0]           rsp_out_width;
   logic [14:0]           rsp_out_height;
   logic [15:0]           rsp_out_confidence;
   logic [7:0]            rsp_out_class;
   logic                  rsp_input_overflowed;
   logic                  rsp_last_of_frame;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int pending_beats;
   int error_count;
   int idle_cycles;
   int rsp_stall;
   bit no_gaps;      // burst mode: sender and receiver never idle

   greedy_box_suppression_unit u_top (.*);

   gbs_checker #(.MAX_DETS(256)) u_checker (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // pick an idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (reset || no_gaps) begin
         rsp_ready <= 1'b1;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= pick_gap();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog: too long with no beat on any channel ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic send_beat(bit has, logic [15:0] x, logic [15:0] y, logic [14:0] w,
                            logic [14:0] h, logic [15:0] conf, logic [7:0] cls, bit fend);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_has_detection <= has;
      req_x_left <= x;
      req_y_top <= y;
      req_box_width <= w;
      req_box_height <= h;
      req_confidence_q16 <= conf;
      req_class_index <= cls;
      req_frame_end <= fend;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and let everything in flight settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_beats != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // one random frame; most boxes clustered so that overlaps are common
   task automatic random_frame(int nbox);
      logic [15:0] bx, by, cbase;
      bit          wild;
      cbase = 16'($urandom());
      bx = 16'($urandom());
      by = 16'($urandom());
      for (int i = 0; i < nbox; i++) begin
         wild = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0)  // ignored beat
            send_beat(1'b0, 16'($urandom()), 16'($urandom()), 15'($urandom()),
                      15'($urandom()), 16'($urandom()), 8'($urandom()), 1'b0);
         if (wild)
            send_beat(1'b1, 16'($urandom()), 16'($urandom()), 15'($urandom()),
                      15'($urandom()), 16'($urandom()), 8'($urandom()), i == nbox - 1);
         else
            send_beat(1'b1, bx + 16'($urandom_range(0, 40)), by + 16'($urandom_range(0, 40)),
                      15'($urandom_range(5, 80)), 15'($urandom_range(5, 80)),
                      cbase + 16'($urandom_range(0, 7)), 8'($urandom()), i == nbox - 1);
      end
      if (nbox == 0)
         send_beat(1'b0, 16'($urandom()), 16'($urandom()), 15'($urandom()),
                   15'($urandom()), 16'($urandom()), 8'($urandom()), 1'b1);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_has_detection = 1'b0;
      req_x_left = '0;
      req_y_top = '0;
      req_box_width = '0;
      req_box_height = '0;
      req_confidence_q16 = '0;
      req_class_index = '0;
      req_frame_end = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      no_gaps = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // extremes, equal-score ties, zero-area pair closing with a box
      send_beat(1'b1, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff, 16'hffff, 8'hff, 1'b0);
      send_beat(1'b1, 16'h8001, 16'h8000, 15'h7fff, 15'h7fff, 16'hffff, 8'h00, 1'b0);
      send_beat(1'b0, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff, 16'hffff, 8'hff, 1'b0); // ignored
      send_beat(1'b1, 16'h7fff, 16'h7fff, 15'h0000, 15'h0000, 16'h0000, 8'h5a, 1'b0);
      send_beat(1'b1, 16'h7fff, 16'h7fff, 15'h0000, 15'h0000, 16'h0000, 8'ha5, 1'b1);
      // empty frame
      send_beat(1'b0, 16'h0, 16'h0, 15'h0, 15'h0, 16'h0, 8'h0, 1'b1);
      // ties with no overlap, closed by a bare end beat
      send_beat(1'b1, 16'd0, 16'd0, 15'd10, 15'd10, 16'd500, 8'd1, 1'b0);
      send_beat(1'b1, 16'd100, 16'd0, 15'd10, 15'd10, 16'd500, 8'd2, 1'b0);
      send_beat(1'b1, 16'd200, 16'd0, 15'd10, 15'd10, 16'd900, 8'd3, 1'b0);
      send_beat(1'b0, 16'd0, 16'd0, 15'd0, 15'd0, 16'd0, 8'd0, 1'b1);

      // any overlap suppresses; cap of zero behaves as one
      write_reg(CSR_IOU_THRESHOLD, 16'd0);
      write_reg(CSR_MAX_RESULTS, 16'd0);
      send_beat(1'b1, 16'd0, 16'd0, 15'd20, 15'd20, 16'd100, 8'd7, 1'b0);
      send_beat(1'b1, 16'd19, 16'd19, 15'd20, 15'd20, 16'd200, 8'd8, 1'b0);
      send_beat(1'b1, 16'd500, 16'd500, 15'd5, 15'd5, 16'd50, 8'd9, 1'b1);
      // only near-identical boxes suppress; oversized cap acts as the limit; bogus index ignored
      write_reg(CSR_IOU_THRESHOLD, 16'hffff);
      write_reg(CSR_MAX_RESULTS, 16'd127);
      write_reg(CSR_UNUSED_INDEX, 16'h1234);
      send_beat(1'b1, 16'd0, 16'd0, 15'd20, 15'd20, 16'd100, 8'd7, 1'b0);
      send_beat(1'b1, 16'd0, 16'd0, 15'd20, 15'd20, 16'd100, 8'd8, 1'b1);

      write_reg(CSR_IOU_THRESHOLD, 16'd29491);
      write_reg(CSR_MAX_RESULTS, 16'd64);

      // random part: settings change every few frames
      for (int f = 0; f < 24; f++) begin
         if (f % 6 == 3) begin
            write_reg(CSR_IOU_THRESHOLD, 16'($urandom()));
            write_reg(CSR_MAX_RESULTS, 16'($urandom_range(1, 8)));
         end else if (f % 6 == 0 && f > 0) begin
            write_reg(CSR_IOU_THRESHOLD,
                      ($urandom_range(0, 1) != 0) ? 16'd29491 : 16'($urandom()));
            write_reg(CSR_MAX_RESULTS,
                      ($urandom_range(0, 1) != 0) ? 16'd64 : 16'($urandom_range(0, 127)));
         end
         no_gaps = (f % 8 == 5);
         if (f == 10) drain();   // sender holds off until all results are in
         random_frame($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 8));
      end
      no_gaps = 1'b0;

      drain();
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ greedy_box_suppression_unit.f @@
rtl/core/gbs_pkg.sv
rtl/core/gbs_front.sv
rtl/core/gbs_overlap.sv
rtl/core/gbs_back.sv
rtl/core/greedy_box_suppression_unit.sv
dv/gbs_checker.sv
dv/tb.sv
